// ===== sv/websocket_frame_unmasker_defines.svh =====
// Assertion macros shared by the frame unmasker RTL.
`ifndef WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define WFU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define WFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/wfu_pkg.sv =====
// Package with item types, codes and constants of the frame unmasker.
`default_nettype none
package wfu_pkg;

  localparam logic [3:0] OPC_CLOSE    = 4'h8;
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;
  localparam logic [3:0] HDR_SHORT    = 4'd6;
  localparam logic [3:0] HDR_MEDIUM   = 4'd8;
  localparam logic [3:0] HDR_LONG     = 4'd14;
  localparam logic [3:0] POS_MAX      = 4'd15;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_CLOSE = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       end_of_message;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } q_push_t;

endpackage
`default_nettype wire

// ===== sv/wfu_front.sv =====
// Front end: header parser, mask key store and payload unmasking.
`default_nettype none
module wfu_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire wfu_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output logic                   in_ready,
  output wfu_pkg::q_push_t       q_push
);

  logic [3:0] pos_r;
  logic [3:0] hdr_size_r;
  logic [7:0] key_r [4];
  logic [1:0] key_idx_r;
  logic       close_r;

  logic [3:0] hdr_size_nxt;
  logic       close_nxt;
  logic [3:0] pos_nxt;
  logic       in_payload;
  logic       key_write;
  logic [1:0] key_slot;
  logic       pay_valid;
  logic       accept;
  logic [1:0] end_status;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hdr_size_nxt = hdr_size_r;
    if (pos_r == 4'd1) begin
      unique case (in_item.data_byte[6:0])
        wfu_pkg::LEN_CODE_16: hdr_size_nxt = wfu_pkg::HDR_MEDIUM;
        wfu_pkg::LEN_CODE_64: hdr_size_nxt = wfu_pkg::HDR_LONG;
        default:              hdr_size_nxt = wfu_pkg::HDR_SHORT;
      endcase
    end
  end

  assign close_nxt  = (pos_r == 4'd0) ? (in_item.data_byte[3:0] == wfu_pkg::OPC_CLOSE)
                                      : close_r;
  // Headers are at least six bytes, so the first two positions never reach payload.
  assign in_payload = (pos_r >= hdr_size_r);
  assign key_write  = (pos_r >= 4'd2) && !in_payload
                      && (pos_r >= hdr_size_r - wfu_pkg::KEY_BYTES);
  // The key starts four bytes before the header end, so its slot is pos minus size mod 4.
  assign key_slot   = pos_r[1:0] - hdr_size_r[1:0];
  assign pay_valid  = in_payload && !close_r;
  assign pos_nxt    = (pos_r == wfu_pkg::POS_MAX) ? pos_r : pos_r + 4'd1;

  always_comb begin
    end_status = wfu_pkg::STATUS_OK;
    if (in_item.last_byte) begin
      if (close_nxt) begin
        end_status = wfu_pkg::STATUS_CLOSE;
      end else if (({1'b0, pos_r} + 5'd1) < {1'b0, hdr_size_nxt}) begin
        end_status = wfu_pkg::STATUS_TRUNC;
      end
    end
  end

  always_comb begin
    q_push.valid               = accept && (pay_valid || in_item.last_byte);
    q_push.item.payload_byte   = pay_valid ? (in_item.data_byte ^ key_r[key_idx_r]) : 8'd0;
    q_push.item.payload_valid  = pay_valid;
    q_push.item.end_of_message = in_item.last_byte;
    q_push.item.status         = end_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 4'd0;
      hdr_size_r <= wfu_pkg::HDR_SHORT;
      key_idx_r  <= 2'd0;
      close_r    <= 1'b0;
    end else if (accept) begin
      if (in_item.last_byte) begin
        pos_r      <= 4'd0;
        hdr_size_r <= wfu_pkg::HDR_SHORT;
        key_idx_r  <= 2'd0;
        close_r    <= 1'b0;
      end else begin
        pos_r      <= pos_nxt;
        hdr_size_r <= hdr_size_nxt;
        close_r    <= close_nxt;
        if (in_payload) begin
          key_idx_r <= key_idx_r + 2'd1;
        end
      end
    end
  end

  // The key is always fully written before a payload byte reads it.
  always_ff @(posedge clk) begin
    if (accept && key_write) begin
      key_r[key_slot] <= in_item.data_byte;
    end
  end

endmodule
`default_nettype wire

// ===== sv/wfu_queue.sv =====
// Back end: short result queue that drives the output channel.
`default_nettype none
module wfu_queue #(
  parameter int DEPTH = wfu_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wfu_pkg::q_push_t q_push,
  output logic                  q_full,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wfu_pkg::out_item_t    out_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wfu_pkg::out_item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign q_full    = (count_r == CNT_FULL);
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign push      = q_push.valid;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= q_push.item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/websocket_frame_unmasker.sv =====
// Top level of the WebSocket frame unmasker.
// Usage:
//   Frame bytes enter on the in_ channel (valid/ready), one item per byte, with
//   last_byte set on the final byte of a message. Results leave on the out_
//   channel: an unmasked payload byte for each payload byte of a data frame,
//   and one item carrying end_of_message and a status for the final byte.
//   Header bytes, and payload bytes of a close frame, give no result.
//   Each result is written into the result queue when its byte is accepted.
//   Throughput: one byte per cycle while out_ready stays high; the header
//   parser and mask XOR finish in the accepting cycle, and the two-entry
//   result queue sets how far input may run ahead of a stalled receiver.
//   When the receiver stalls, results collect in the queue and in_ready
//   falls once it is full; nothing is dropped.
//   Reset (rst_n low, synchronous) empties the queue and returns the parser
//   to the first byte of a frame. After every final byte the parser also
//   restarts, so the next byte opens a new frame.
`default_nettype none
`include "websocket_frame_unmasker_defines.svh"
module websocket_frame_unmasker #(
  parameter int QUEUE_DEPTH = wfu_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire wfu_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wfu_pkg::out_item_t      out_item
);

  wfu_pkg::q_push_t q_push;
  logic             q_full;

  wfu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_full   (q_full),
    .in_ready (in_ready),
    .q_push   (q_push)
  );

  wfu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_full    (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  `WFU_ASSERT_SAME(a_no_close_payload, out_valid && out_item.payload_valid, out_item.status != wfu_pkg::STATUS_CLOSE, "payload byte emitted with close status")
  `WFU_ASSERT_SAME(a_status_at_end, out_valid && !out_item.end_of_message, out_item.status == wfu_pkg::STATUS_OK, "status set on a result that is not the end")
  `WFU_ASSERT_NEXT(a_push_shows, q_push.valid, out_valid, "queued result not visible on the output")

endmodule
`default_nettype wire

// ===== test/websocket_frame_unmasker_checker.sv =====
// Checker that predicts the unmasker's results and compares them as they leave the block.
module websocket_frame_unmasker_checker
  import wfu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  logic [3:0] frame_pos;
  logic [3:0] hdr_len;
  logic [7:0] key [4];
  logic [1:0] key_idx;
  logic       is_close;
  int         mismatches = 0;
  out_item_t  unmasked_q[$];

  task automatic clear_frame();
    frame_pos = 4'd0;
    hdr_len   = HDR_SHORT;
    for (int i = 0; i < 4; i++) key[i] = 8'h00;
    key_idx   = 2'd0;
    is_close  = 1'b0;
  endtask

  task automatic predict_byte(input in_item_t it);
    logic [3:0] pos;
    out_item_t  res;
    pos = frame_pos;
    res = '0;
    if (pos == 4'd0) begin
      is_close = (it.data_byte[3:0] == OPC_CLOSE);
    end else if (pos == 4'd1) begin
      case (it.data_byte[6:0])
        LEN_CODE_16: hdr_len = HDR_MEDIUM;
        LEN_CODE_64: hdr_len = HDR_LONG;
        default:     hdr_len = HDR_SHORT;
      endcase
    end else if (pos < hdr_len) begin
      // The last four header bytes hold the mask key; extended length bytes are skipped.
      if (pos >= hdr_len - KEY_BYTES)
        key[2'(pos - (hdr_len - KEY_BYTES))] = it.data_byte;
    end else begin
      if (!is_close) begin
        res.payload_byte  = it.data_byte ^ key[key_idx];
        res.payload_valid = 1'b1;
      end
      key_idx = key_idx + 2'd1;
    end
    if (frame_pos != POS_MAX) frame_pos = frame_pos + 4'd1;
    if (res.payload_valid || it.last_byte) begin
      res.end_of_message = it.last_byte;
      if (it.last_byte) begin
        if (is_close)
          res.status = STATUS_CLOSE;
        else if ({1'b0, pos} + 5'd1 < {1'b0, hdr_len})
          res.status = STATUS_TRUNC;
        else
          res.status = STATUS_OK;
      end
      unmasked_q.push_back(res);
    end
    if (it.last_byte) clear_frame();
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      unmasked_q.delete();
      clear_frame();
    end else begin
      // Results are checked before the new item is predicted, since a result
      // never leaves in the cycle its byte is accepted.
      if (out_valid && out_ready) begin
        if (unmasked_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %h valid %b eom %b status %0d",
                     out_item.payload_byte, out_item.payload_valid,
                     out_item.end_of_message, out_item.status);
        end else begin
          want = unmasked_q.pop_front();
          if (out_item.payload_byte !== want.payload_byte ||
              out_item.payload_valid !== want.payload_valid ||
              out_item.end_of_message !== want.end_of_message ||
              out_item.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected byte %h valid %b eom %b status %0d, got byte %h valid %b eom %b status %0d",
                       want.payload_byte, want.payload_valid, want.end_of_message, want.status,
                       out_item.payload_byte, out_item.payload_valid,
                       out_item.end_of_message, out_item.status);
          end
        end
      end
      if (in_valid && in_ready) predict_byte(in_item);
    end
    pending    <= unmasked_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== test/tb_websocket_frame_unmasker.sv =====
// Testbench top: drives frames into the unmasker, throttles its output and gives the verdict.
module tb_websocket_frame_unmasker;
  import wfu_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int QUIET_FROM  = 1600;
  localparam int CYCLE_LIMIT = 300000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int   fail_count;
  int   pending;
  int   bytes_sent = 0;
  int   cycles     = 0;
  int   stall_left = 0;
  logic quiet      = 1'b0;

  websocket_frame_unmasker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  websocket_frame_unmasker_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stalls come in random bursts.
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready  <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Sends a message of total bytes; everything after the first two is random.
  task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1, input int total);
    logic [7:0] b;
    for (int i = 0; i < total; i++) begin
      b = (i == 0) ? b0 : (i == 1) ? b1 : 8'($urandom);
      send_byte(b, i == total - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int         kind;
    int         sel;
    int         len;
    int         hdr;
    logic [7:0] b0;
    logic [7:0] b1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Close frame carrying payload, which must stay suppressed.
    send_frame(8'h88, 8'h80, 7);
    // Message that ends on its first byte: truncated header.
    send_frame(8'h00, 8'h00, 1);
    // Close frame cut short inside the header still reports close.
    send_frame(8'hF8, 8'hFF, 2);
    // 16-bit length code with an empty payload.
    send_frame(8'h82, 8'hFE, 8);
    // Short header with two payload bytes.
    send_frame(8'hFF, 8'h7D, 8);
    drain();

    while (bytes_sent < ITEM_TARGET) begin
      quiet <= (bytes_sent >= QUIET_FROM);
      kind = $urandom_range(0, 99);
      sel  = $urandom_range(0, 2);
      b0   = 8'($urandom);
      b1   = 8'($urandom);
      b1[6:0] = (sel == 0) ? 7'($urandom_range(0, 125)) :
                (sel == 1) ? LEN_CODE_16 : LEN_CODE_64;
      hdr  = (sel == 0) ? int'(HDR_SHORT) : (sel == 1) ? int'(HDR_MEDIUM) : int'(HDR_LONG);
      if (kind < 70) begin
        if (b0[3:0] == OPC_CLOSE) b0[0] = 1'b1;
        // Mostly short payloads; a few run long enough to saturate the position.
        len = hdr + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 8));
      end else if (kind < 80) begin
        b0[3:0] = OPC_CLOSE;
        len = $urandom_range(1, hdr + 6);
      end else if (kind < 95) begin
        if (b0[3:0] == OPC_CLOSE) b0[0] = 1'b1;
        len = $urandom_range(1, hdr - 1);
      end else begin
        len = $urandom_range(1, 20);
      end
      send_frame(b0, b1, len);
      if ($urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
